FILE: hdl/assert_macros.svh
// Assertion macros for the ray/box wall distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define RBWD_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rbwd: implication check failed");

// Next-cycle implication, disabled while rst is high.
`define RBWD_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rbwd: next-cycle check failed");

`endif

FILE: hdl/rbwd_pkg.sv
// ----------------------------------------------------------------------------
// rbwd_pkg
// Shared constants, types and the arctangent table of the wall distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbwd_pkg;

  localparam int DIR_FRAC_BITS         = 14;
  localparam int CORDIC_STEPS          = 14;
  localparam int CORDIC_START          = 9949;
  localparam int POS_FRAC_BITS_DEFAULT = 7;
  localparam int FHS_W                 = 15;
  localparam int RANGE_W               = 16;
  localparam int CFG_DATA_W            = 16;
  localparam int FHS_RESET             = 9216;
  localparam int RANGE_RESET           = 2000;
  localparam int Q_W                   = 17;   // quotient bits, one above the 16-bit range
  localparam int E_W                   = 19;   // divisor 10*|c|
  localparam int ANG_W                 = 17;   // CORDIC residual angle and vector width

  typedef enum logic [0:0] {
    REG_FIELD_HALF_SIZE = 1'b0,
    REG_RANGE_CAP       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] c;
    logic signed [15:0] s;
  } geo_t;

  typedef struct packed {
    logic        any;
    logic [15:0] dmag;
    logic [15:0] cmag;
  } div_in_t;

  typedef struct packed {
    logic           any;
    logic           ovf;
    logic [Q_W-1:0] q;
  } div_out_t;

  function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [3:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      4'd0:    a = 17'sd8192;
      4'd1:    a = 17'sd4836;
      4'd2:    a = 17'sd2555;
      4'd3:    a = 17'sd1297;
      4'd4:    a = 17'sd651;
      4'd5:    a = 17'sd326;
      4'd6:    a = 17'sd163;
      4'd7:    a = 17'sd81;
      4'd8:    a = 17'sd41;
      4'd9:    a = 17'sd20;
      4'd10:   a = 17'sd10;
      4'd11:   a = 17'sd5;
      4'd12:   a = 17'sd3;
      4'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ray_box_wall_distance_core.sv
// Ray to square-field wall distance. Each transaction carries a sensor pose
// (x, y in 1/2^POS_FRAC_BITS inch, heading as a 16-bit binary angle) and
// returns the distance in millimetres to the nearest wall of a square field
// of half size field_half_size centred on the origin, capped at the configured
// maximum range, with wall_hit set when a wall is strictly nearer than that
// cap. One pose is taken every cycle unless in_stall is high. The pipeline is one input
// register, 14 CORDIC rotation stages and a sign stage, four geometry stages
// (products, hit tests, cross products, selection), a dividend stage, an
// overflow stage and 17 quotient-bit stages of the divider, and the output
// register. A stalled output holds the pipeline only once its last stage is
// full. The user must write configuration registers through cfg_wen,
// cfg_index and cfg_data only while idle; the core does not enforce this.
`default_nettype none

module ray_box_wall_distance_core #(
  parameter int POS_FRAC_BITS = rbwd_pkg::POS_FRAC_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              pos_x,
  input  wire logic signed [15:0]              pos_y,
  input  wire logic [15:0]                     heading,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [15:0]                          distance_mm,
  output logic                                 wall_hit,
  input  wire logic                            cfg_wen,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [rbwd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbwd_pkg::*;

  logic [FHS_W-1:0]   field_half_size;
  logic [RANGE_W-1:0] range_cap;
  logic               en;
  pose_t              pose;
  logic               c_v, g_v, d_v;
  geo_t               geo;
  div_in_t            dv;
  div_out_t           dq;
  logic               near;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_half_size <= FHS_W'(FHS_RESET);
      range_cap       <= RANGE_W'(RANGE_RESET);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIELD_HALF_SIZE: field_half_size <= cfg_data[FHS_W-1:0];
        REG_RANGE_CAP:       range_cap       <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // advance unless the last stage holds a result the output cannot take
  assign en       = !d_v || !out_valid || !out_stall;
  assign in_stall = !en;

  assign pose.pos_x   = pos_x;
  assign pose.pos_y   = pos_y;
  assign pose.heading = heading;

  rbwd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .pose  (pose),
    .out_v (c_v),
    .geo   (geo)
  );

  rbwd_geom u_geom (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .field_half_size (field_half_size),
    .in_v            (c_v),
    .geo             (geo),
    .out_v           (g_v),
    .dv              (dv)
  );

  rbwd_div #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (g_v),
    .dv    (dv),
    .out_v (d_v),
    .dq    (dq)
  );

  assign near = dq.any && !dq.ovf && (dq.q < Q_W'(range_cap));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      distance_mm <= near ? dq.q[RANGE_W-1:0] : range_cap;
      wall_hit    <= near;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rbwd_cordic.sv
// ----------------------------------------------------------------------------
// rbwd_cordic
// Pipelined CORDIC: heading to Q14 cosine and sine, one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbwd_cordic (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_v,
  input  rbwd_pkg::pose_t    pose,
  output logic               out_v,
  output rbwd_pkg::geo_t     geo
);
  import rbwd_pkg::*;

  logic                    v  [0:CORDIC_STEPS];
  logic                    fl [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] x  [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] y  [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z  [0:CORDIC_STEPS];
  logic signed [15:0]      px [0:CORDIC_STEPS];
  logic signed [15:0]      py [0:CORDIC_STEPS];

  // fold the half turn through +-32768 away; the residual angle is the heading
  // with bit 15 replaced by bit 14
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= pose.heading[15] ^ pose.heading[14];
      x[0]  <= ANG_W'(CORDIC_START);
      y[0]  <= '0;
      z[0]  <= {pose.heading[14], pose.heading[14], pose.heading[14:0]};
      px[0] <= pose.pos_x;
      py[0] <= pose.pos_y;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        px[i+1] <= px[i];
        py[i+1] <= py[i];
        if (!z[i][ANG_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - cordic_atan(4'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + cordic_atan(4'(i));
        end
      end
    end
  end

  // undo the fold: negate both components
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo.px <= px[CORDIC_STEPS];
      geo.py <= py[CORDIC_STEPS];
      geo.c  <= fl[CORDIC_STEPS] ? 16'(-x[CORDIC_STEPS]) : 16'(x[CORDIC_STEPS]);
      geo.s  <= fl[CORDIC_STEPS] ? 16'(-y[CORDIC_STEPS]) : 16'(y[CORDIC_STEPS]);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rbwd_geom.sv
// ----------------------------------------------------------------------------
// rbwd_geom
// Wall hit tests and nearest-wall selection, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rbwd_geom (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [14:0]          field_half_size,
  input  wire logic                 in_v,
  input  rbwd_pkg::geo_t            geo,
  output logic                      out_v,
  output rbwd_pkg::div_in_t         dv
);
  import rbwd_pkg::*;

  // stage M: products and wall offsets
  logic               m_v;
  logic signed [31:0] m_yc, m_xs, m_hc, m_hs;
  logic signed [16:0] m_dv0, m_dv1, m_dh0, m_dh1;
  logic signed [15:0] m_c, m_s;
  logic               m_hnz;

  // stage V: per-axis nearest valid wall
  logic               w_v;
  logic               w_vv, w_hv;
  logic [15:0]        w_dvm, w_dhm, w_cm, w_sm;

  // stage X: cross products
  logic               x_v;
  logic               x_vv, x_hv;
  logic [15:0]        x_dvm, x_dhm, x_cm, x_sm;
  logic [31:0]        x_pv, x_ph;

  logic signed [16:0] hx, pxx, pyx;
  logic signed [15:0] h16;

  assign h16 = signed'({1'b0, field_half_size});
  assign hx  = signed'({2'b00, field_half_size});
  assign pxx = 17'(geo.px);
  assign pyx = 17'(geo.py);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      w_v <= 1'b0;
      x_v <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      m_v <= in_v;
      w_v <= m_v;
      x_v <= w_v;
      out_v <= x_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_yc  <= geo.py * geo.c;
      m_xs  <= geo.px * geo.s;
      m_hc  <= h16 * geo.c;
      m_hs  <= h16 * geo.s;
      m_dv0 <= -hx - pxx;
      m_dv1 <= hx - pxx;
      m_dh0 <= -hx - pyx;
      m_dh1 <= hx - pyx;
      m_c   <= geo.c;
      m_s   <= geo.s;
      m_hnz <= |field_half_size;
    end
  end

  // along-wall coordinate of each hit, scaled by the crossing component
  logic signed [32:0] av;
  logic signed [33:0] a_v0, a_v1, a_h0, a_h1;
  logic [33:0]        ab_v0, ab_v1, ab_h0, ab_h1;
  logic [31:0]        lim_c, lim_s;
  logic               ok_v0, ok_v1, ok_h0, ok_h1;
  logic [15:0]        mg_v0, mg_v1, mg_h0, mg_h1;
  logic               c_nz, s_nz;

  always_comb begin
    av    = 33'(m_yc) - 33'(m_xs);
    a_v0  = 34'(av) - 34'(m_hs);
    a_v1  = 34'(av) + 34'(m_hs);
    a_h0  = -34'(av) - 34'(m_hc);
    a_h1  = -34'(av) + 34'(m_hc);
    ab_v0 = a_v0[33] ? 34'(-a_v0) : 34'(a_v0);
    ab_v1 = a_v1[33] ? 34'(-a_v1) : 34'(a_v1);
    ab_h0 = a_h0[33] ? 34'(-a_h0) : 34'(a_h0);
    ab_h1 = a_h1[33] ? 34'(-a_h1) : 34'(a_h1);
    lim_c = m_hc[31] ? 32'(-m_hc) : 32'(m_hc);
    lim_s = m_hs[31] ? 32'(-m_hs) : 32'(m_hs);
    c_nz  = |m_c;
    s_nz  = |m_s;
    // in front of the sensor: offset zero or of the same sign as the component
    ok_v0 = m_hnz && c_nz && ((m_dv0 == '0) || (m_dv0[16] == m_c[15]))
            && (ab_v0 <= 34'(lim_c));
    ok_v1 = m_hnz && c_nz && ((m_dv1 == '0) || (m_dv1[16] == m_c[15]))
            && (ab_v1 <= 34'(lim_c));
    ok_h0 = m_hnz && s_nz && ((m_dh0 == '0) || (m_dh0[16] == m_s[15]))
            && (ab_h0 <= 34'(lim_s));
    ok_h1 = m_hnz && s_nz && ((m_dh1 == '0) || (m_dh1[16] == m_s[15]))
            && (ab_h1 <= 34'(lim_s));
    mg_v0 = m_dv0[16] ? 16'(-m_dv0) : 16'(m_dv0);
    mg_v1 = m_dv1[16] ? 16'(-m_dv1) : 16'(m_dv1);
    mg_h0 = m_dh0[16] ? 16'(-m_dh0) : 16'(m_dh0);
    mg_h1 = m_dh1[16] ? 16'(-m_dh1) : 16'(m_dh1);
  end

  // same component on both walls of an axis: the smaller offset is nearer
  always_ff @(posedge clk) begin
    if (en) begin
      w_vv  <= ok_v0 || ok_v1;
      w_hv  <= ok_h0 || ok_h1;
      w_dvm <= (ok_v0 && (!ok_v1 || mg_v0 <= mg_v1)) ? mg_v0 : mg_v1;
      w_dhm <= (ok_h0 && (!ok_h1 || mg_h0 <= mg_h1)) ? mg_h0 : mg_h1;
      w_cm  <= m_c[15] ? 16'(-m_c) : 16'(m_c);
      w_sm  <= m_s[15] ? 16'(-m_s) : 16'(m_s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_vv  <= w_vv;
      x_hv  <= w_hv;
      x_dvm <= w_dvm;
      x_dhm <= w_dhm;
      x_cm  <= w_cm;
      x_sm  <= w_sm;
      x_pv  <= w_dvm * w_sm;
      x_ph  <= w_dhm * w_cm;
    end
  end

  // compare |dv|/|c| against |dh|/|s| by cross products
  always_ff @(posedge clk) begin
    if (en) begin
      dv.any <= x_vv || x_hv;
      if (x_vv && (!x_hv || x_pv <= x_ph)) begin
        dv.dmag <= x_dvm;
        dv.cmag <= x_cm;
      end else begin
        dv.dmag <= x_dhm;
        dv.cmag <= x_sm;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rbwd_div.sv
// ----------------------------------------------------------------------------
// rbwd_div
// Millimetre conversion with round-half-up: pipelined restoring divider,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbwd_div #(
  parameter int POS_FRAC_BITS = rbwd_pkg::POS_FRAC_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_v,
  input  rbwd_pkg::div_in_t  dv,
  output logic               out_v,
  output rbwd_pkg::div_out_t dq
);
  import rbwd_pkg::*;

  localparam int SHIFT = DIR_FRAC_BITS - POS_FRAC_BITS;
  localparam int NUM_W = 23 + SHIFT;
  localparam int D_W   = NUM_W + 2;

  // stage P: dividend 2*num + den, divisor 2*den
  logic               p_v, p_any;
  logic [D_W-1:0]     p_d;
  logic [E_W-1:0]     p_e;
  logic [D_W-1:0]     p_prod;

  assign p_prod = D_W'(dv.dmag) * D_W'(127);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_any <= dv.any;
      p_d   <= (p_prod << (SHIFT + 1)) + D_W'(dv.cmag) * D_W'(5);
      p_e   <= E_W'(dv.cmag) * E_W'(10);
    end
  end

  // stage chain: index 0 is the overflow check, then one stage per bit
  logic           v   [0:Q_W];
  logic           any [0:Q_W];
  logic           ovf [0:Q_W];
  logic [E_W-1:0] e   [0:Q_W];
  logic [E_W-1:0] rem [0:Q_W];
  logic [Q_W-1:0] lo  [0:Q_W];
  logic [Q_W-1:0] q   [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= p_v;
    end
  end

  // the high part is below the divisor unless the quotient overflows
  always_ff @(posedge clk) begin
    if (en) begin
      any[0] <= p_any;
      ovf[0] <= (p_d >> Q_W) >= D_W'(p_e);
      e[0]   <= p_e;
      rem[0] <= E_W'(p_d >> Q_W);
      lo[0]  <= p_d[Q_W-1:0];
      q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    logic [E_W:0] t;
    logic         ge;

    assign t  = {rem[k], lo[k][Q_W-1]};
    assign ge = t >= {1'b0, e[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        any[k+1] <= any[k];
        ovf[k+1] <= ovf[k];
        e[k+1]   <= e[k];
        rem[k+1] <= ge ? E_W'(t - {1'b0, e[k]}) : E_W'(t);
        lo[k+1]  <= lo[k] << 1;
        q[k+1]   <= {q[k][Q_W-2:0], ge};
      end
    end
  end

  assign out_v  = v[Q_W];
  assign dq.any = any[Q_W];
  assign dq.ovf = ovf[Q_W];
  assign dq.q   = q[Q_W];

endmodule

`default_nettype wire

FILE: hdl/rbwd_checker.sv
// ----------------------------------------------------------------------------
// rbwd_checker
// Port-level checks on the wall distance core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbwd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] distance_mm,
  input wire logic        wall_hit
);

  // reset empties the output register
  `RBWD_ASSERT_NXT(a_rst_empty, clk, 1'b0, rst, !out_valid)

  // an empty output register never back-pressures the input
  `RBWD_ASSERT_IMP(a_empty_accepts, clk, 1'b0, !out_valid, !in_stall)

  // a result taken this cycle frees the pipeline
  `RBWD_ASSERT_IMP(a_drain_accepts, clk, rst, out_valid && !out_stall, !in_stall)

  // a stalled transaction holds
  `RBWD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(distance_mm) && $stable(wall_hit))

endmodule

bind ray_box_wall_distance_core rbwd_checker u_rbwd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .distance_mm (distance_mm),
  .wall_hit    (wall_hit)
);

`default_nettype wire

FILE: test/ray_box_wall_distance_core_test.sv
// ----------------------------------------------------------------------------
// ray_box_wall_distance_core_test
// Drives random and directed poses through the wall distance core, predicts
// each distance with an integer CORDIC and exact wall tests, and compares
// every result in order. Walks several field sizes and range caps.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_wall_distance_core_test;
  import rbwd_pkg::*;

  localparam int PFB = POS_FRAC_BITS_DEFAULT;
  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [15:0] mm;
    logic        hit;
  } wall_reading_t;

  class wall_scoreboard;
    int unsigned half_size = FHS_RESET;
    int unsigned range_cap = RANGE_RESET;
    wall_reading_t pending[$];
    int errors = 0;

    function automatic int floor_sh(int v, int sh);
      return v >>> sh;
    endfunction

    function automatic void heading_to_dir(logic [15:0] hd, output longint c,
                                           output longint s);
      int z, x, y, xs, ys;
      bit flip;
      z = hd; flip = 0; x = CORDIC_START; y = 0;
      if (z >= 16384 && z < 49152) begin
        z -= 32768; flip = 1;
      end else if (z >= 49152) begin
        z -= 65536;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = floor_sh(x, i);
        ys = floor_sh(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= cordic_atan(i[3:0]);
        end else begin
          x += ys; y -= xs; z += cordic_atan(i[3:0]);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = x; s = y;
    endfunction

    function automatic longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // -1 when the wall is parallel, behind, or missed along its length
    function automatic longint wall_mm(longint w, longint pa, longint pb,
                                       longint ca, longint cb, longint h);
      longint d, along, num, den;
      d = w - pa;
      if (ca == 0) return -1;
      if ((d < 0 && ca > 0) || (d > 0 && ca < 0)) return -1;
      along = pb * ca + d * cb;
      if (mag(along) > h * mag(ca)) return -1;
      num = (mag(d) * 127) <<< (DIR_FRAC_BITS - PFB);
      den = 5 * mag(ca);
      return (2 * num + den) / (2 * den);
    endfunction

    function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic [15:0] hd);
      longint c, s, h, best, dk[4];
      wall_reading_t r;
      h = half_size;
      best = range_cap;
      heading_to_dir(hd, c, s);
      if (h != 0) begin
        dk[0] = wall_mm(-h, px, py, c, s, h);
        dk[1] = wall_mm(h, px, py, c, s, h);
        dk[2] = wall_mm(-h, py, px, s, c, h);
        dk[3] = wall_mm(h, py, px, s, c, h);
        foreach (dk[k]) if (dk[k] >= 0 && dk[k] < best) best = dk[k];
      end
      r.mm = best[15:0];
      r.hit = best < longint'(range_cap);
      pending = {pending, r};
    endfunction

    function void check_reading(logic [15:0] mm, logic hit);
      wall_reading_t e;
      if (pending.size() == 0) begin
        $error("unexpected result distance_mm=%0d", mm);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (mm !== e.mm) begin
        $error("distance_mm expected %0d actual %0d", e.mm, mm);
        errors++;
      end
      if (hit !== e.hit) begin
        $error("wall_hit expected %0d actual %0d", e.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic signed [15:0] pos_x = 0, pos_y = 0;
  logic [15:0] heading = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] distance_mm;
  logic wall_hit;
  logic cfg_wen = 0;
  logic [0:0] cfg_index = REG_FIELD_HALF_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  wall_scoreboard board = new();
  bit hold_off = 0;
  bit poses_done = 0;
  int idle_cycles = 0;

  ray_box_wall_distance_core dut (.*);

  initial forever #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wen <= 0;
    if (idx == REG_FIELD_HALF_SIZE) board.half_size = val & 16'h7FFF;
    else board.range_cap = val & 16'hFFFF;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // Present one pose, hold until taken; valid stays up across back-to-back poses
  task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                           logic [15:0] hd, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    pos_x <= px;
    pos_y <= py;
    heading <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pose(px, py, hd);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_pos(int unsigned hs);
    int r, lim;
    r = $urandom_range(0, 9);
    lim = hs + 200;
    if (r < 7) return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    if (r < 9) return 16'($urandom);
    return 16'($urandom_range(0, 1) ? 32767 : -32768);
  endfunction

  function automatic logic [15:0] rand_heading();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom);
    return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_pose(rand_pos(board.half_size), rand_pos(board.half_size),
                rand_heading(), gap_len());
    end_burst();
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int g;
    out_stall <= 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (150) @(negedge clk);
        out_stall <= 0;
        hold_off = 0;
      end else begin
        g = gap_len();
        if (g > 0 && $urandom_range(0, 3) != 0) begin
          out_stall <= 1;
          repeat (g) @(negedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_reading(distance_mm, wall_hit);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || poses_done)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sizes[6] = '{9216, 1, 32767, 0, 600, 20000};
    int unsigned caps[6] = '{2000, 0, 65535, 65535, 300, 40000};
    int unsigned hs;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: axis headings, corners, edges, extremes
    hs = board.half_size;
    send_pose(0, 0, 16'h0000, 0);
    send_pose(0, 0, 16'h4000, 0);
    send_pose(0, 0, 16'h8000, 0);
    send_pose(0, 0, 16'hC000, 0);
    send_pose(0, 0, 16'h2000, 0);
    send_pose(0, 0, 16'hFFFF, 0);
    send_pose(16'(hs), 16'(hs), 16'h6000, 0);
    send_pose(16'(-hs), 16'(-hs), 16'h2000, 0);
    send_pose(16'(hs), 0, 16'h0000, 0);
    send_pose(16'(hs), 0, 16'h8000, 0);
    send_pose(16'sh7FFF, 16'sh7FFF, 16'hA000, 0);
    send_pose(-16'sh8000, -16'sh8000, 16'h2000, 0);
    send_pose(-16'sh8000, 0, 16'h0000, 0);
    send_pose(16'sh7FFF, 0, 16'h0001, 0);
    send_pose(0, 16'sh7FFF, 16'hC000, 0);
    send_pose(100, -100, 16'h3FFF, 1);
    send_pose(-5, 7, 16'hBFFF, 0);
    send_pose(16'h5555, 16'hAAAA, 16'h5555, 0);
    send_pose(16'hAAAA, 16'h5555, 16'hAAAA, 0);
    end_burst();

    // long receiver hold-off while poses keep coming
    hold_off = 1;
    for (int i = 0; i < 120; i++)
      send_pose(rand_pos(hs), rand_pos(hs), rand_heading(), 0);
    end_burst();
    // sender waits for every result
    drain();

    for (int p = 0; p < 6; p++) begin
      drain();
      repeat (LATENCY + 5) @(negedge clk);
      write_reg(REG_FIELD_HALF_SIZE, sizes[p]);
      write_reg(REG_RANGE_CAP, caps[p]);
      if (sizes[p] == 0) begin
        send_pose(0, 0, 16'h0000, 0);
        send_pose(16'sh7FFF, 0, 16'h8000, 0);
        end_burst();
      end
      random_phase(p == 0 ? 500 : 185);
    end

    drain();
    poses_done = 1;
    repeat (LATENCY + 10) @(negedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d results never arrived", board.pending.size());
      board.errors++;
    end
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // bound the final drain as well
  initial begin
    wait (poses_done);
    repeat (WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
